// ===== hw/rtl/assert_macros.svh =====
// Concurrent assertion helpers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// when pre holds, post must hold in the next cycle
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== hw/rtl/lrutr_pkg.sv =====
package lrutr_pkg;

   localparam int DEPTH    = 16;
   localparam int TAG_BITS = 32;
   localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 48;
   localparam int CSR_W       = 5;
   localparam logic [CSR_W-1:0] CAP_RESET = CSR_W'(16);

   typedef logic [TAG_BITS-1:0] tag_type;
   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [CNT_W-1:0]    cnt_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic    load;
      idx_type stop_idx;
      cnt_type count;
      tag_type req_tag;
   } cell_ctl_type;

   typedef struct packed {
      logic match;
      logic last;
   } cell_sts_type;

endpackage

// ===== hw/rtl/lrutr_cell.sv =====
module lrutr_cell (
   input  logic                   clock,
   input  lrutr_pkg::idx_type     idx,
   input  lrutr_pkg::cell_ctl_type ctl,
   input  lrutr_pkg::tag_type     prev_tag,
   output lrutr_pkg::tag_type     tag,
   output lrutr_pkg::cell_sts_type sts
);

   lrutr_pkg::tag_type tag_ff;
   lrutr_pkg::tag_type tag_in;
   lrutr_pkg::cnt_type idx_cnt;
   logic               valid;
   logic               shift;

   assign idx_cnt = lrutr_pkg::CNT_W'(idx);
   assign valid   = idx_cnt < ctl.count;
   assign shift   = ctl.load && (idx <= ctl.stop_idx);

   assign sts.match = valid && (tag_ff == ctl.req_tag);
   assign sts.last  = (ctl.count != '0) && (idx_cnt == ctl.count - 1'b1);
   assign tag       = tag_ff;

   assign tag_in = shift ? prev_tag : tag_ff;

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

endmodule

// ===== hw/rtl/lru_tag_recency_list.sv =====
// LRU recency list of address tags, most recent first.
// Input stream req_*: one transaction per access, req_tdata carries the tag.
// Output stream rsp_*: one transaction per access with hit, hit rank, the
// evicted tag if any, and the fill count after the access.
// csr_wr_en/csr_wr_data write the capacity (0 acts as 1, above 16 as 16);
// write it only while no access is in flight.
// rsp_tvalid rises in the cycle after req acceptance; one access per cycle
// is sustained while rsp_tready stays high. The tags sit in a row of cells,
// slot k holding the tag of recency rank k; an access shifts the row down by
// one up to the hit slot (the first free slot on insert, the last filled slot
// on evict) and loads the new tag into slot 0, all in the acceptance cycle.
// Reset empties the list and sets the capacity to 16; tag storage is not
// cleared. A stalled rsp holds its output register and blocks req_tready
// until it is taken.
module lru_tag_recency_list (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lrutr_pkg::REQ_TDATA_W-1:0] req_tdata,  // [31:0] tag
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] hit, [4:1] hit_rank, [5] evict_valid, [37:6] evicted_tag,
   // [42:38] fill_count, [47:43] zero
   output logic [lrutr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic [lrutr_pkg::CSR_W-1:0]       csr_wr_data
);

   `include "assert_macros.svh"

   logic [lrutr_pkg::CSR_W-1:0] cap_ff;
   lrutr_pkg::cnt_type          count_ff, count_in, cap_eff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [42:0]                 rsp_data_ff, rsp_data_in;

   lrutr_pkg::cell_ctl_type     ctl;
   lrutr_pkg::cell_sts_type     sts [lrutr_pkg::DEPTH];
   lrutr_pkg::tag_type          chain [lrutr_pkg::DEPTH+1];
   logic [lrutr_pkg::DEPTH-1:0] match_vec;

   logic                        accept, hit, evict;
   lrutr_pkg::idx_type          rank;
   lrutr_pkg::tag_type          ev_tag;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      priority if (cap_ff == '0) begin
         cap_eff = lrutr_pkg::CNT_W'(1);
      end else if (32'(cap_ff) > 32'(lrutr_pkg::DEPTH)) begin
         cap_eff = lrutr_pkg::CNT_W'(lrutr_pkg::DEPTH);
      end else begin
         cap_eff = lrutr_pkg::CNT_W'(cap_ff);
      end
   end

   assign chain[0] = lrutr_pkg::TAG_BITS'(req_tdata);

   genvar gi;
   generate
      for (gi = 0; gi < lrutr_pkg::DEPTH; gi++) begin : g_cell
         lrutr_cell u_cell (
            .clock    (clock),
            .idx      (lrutr_pkg::IDX_W'(gi)),
            .ctl      (ctl),
            .prev_tag (chain[gi]),
            .tag      (chain[gi+1]),
            .sts      (sts[gi])
         );
         assign match_vec[gi] = sts[gi].match;
      end
   endgenerate

   always_comb begin
      rank   = '0;
      ev_tag = '0;
      for (int i = 0; i < lrutr_pkg::DEPTH; i++) begin
         rank   = rank | (sts[i].match ? lrutr_pkg::IDX_W'(i) : '0);
         ev_tag = ev_tag | (sts[i].last ? chain[i+1] : '0);
      end
   end

   assign hit   = |match_vec;
   assign evict = !hit && (count_ff >= cap_eff);

   always_comb begin
      ctl.load    = accept;
      ctl.count   = count_ff;
      ctl.req_tag = lrutr_pkg::TAG_BITS'(req_tdata);
      priority if (hit) begin
         ctl.stop_idx = rank;
      end else if (evict) begin
         ctl.stop_idx = lrutr_pkg::IDX_W'(count_ff - 1'b1);
      end else begin
         ctl.stop_idx = lrutr_pkg::IDX_W'(count_ff);
      end
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         if (!hit && !evict) begin
            count_in = count_ff + 1'b1;
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'(count_in),
                         32'(evict ? ev_tag : '0),
                         evict,
                         4'(hit ? rank : '0),
                         hit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= lrutr_pkg::CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff};

   `ASSERT_ALWAYS(a_count_bound, clock, reset,
      32'(count_ff) <= 32'(lrutr_pkg::DEPTH), "fill count above depth")
   `ASSERT_ALWAYS(a_match_unique, clock, reset,
      $onehot0(match_vec), "tag held in more than one slot")
   `ASSERT_ALWAYS(a_hit_no_evict, clock, reset,
      !(rsp_valid_ff && rsp_data_ff[0] && rsp_data_ff[5]), "hit reported with eviction")
   `ASSERT_NEXT(a_insert_grows, clock, reset,
      accept && !hit && !evict, count_ff == $past(count_ff) + 1'b1, "insert did not grow list")
   `ASSERT_NEXT(a_stall_holds, clock, reset,
      rsp_valid_ff && !rsp_tready, rsp_valid_ff && $stable(rsp_data_ff), "stalled result changed")

endmodule
